[hw/rtl/nkps_pkg.sv]
// ----------------------------------------------------------------------------
// nkps_pkg
// Shared constants and types for the nearest-k point selector.
// ----------------------------------------------------------------------------
package nkps_pkg;

  // table and selection sizes
  localparam int MAX_ZONES     = 256;
  localparam int NEAREST_COUNT = 8;
  localparam int IDX_W         = $clog2(MAX_ZONES);
  localparam int K_W           = $clog2(NEAREST_COUNT);

  // field widths
  localparam int COORD_W = 20;
  localparam int FLAGS_W = 16;
  localparam int CFG_W   = 9;
  localparam int RANK_W  = 3;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int DIST_W  = SQ_W + 2;

  // item function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // one stored zone entry
  typedef struct packed {
    logic signed [COORD_W-1:0] base_x;
    logic signed [COORD_W-1:0] base_y;
    logic signed [COORD_W-1:0] base_z;
    logic signed [COORD_W-1:0] dest_x;
    logic signed [COORD_W-1:0] dest_y;
    logic signed [COORD_W-1:0] dest_z;
    logic signed [COORD_W-1:0] distance;
    logic [FLAGS_W-1:0]        flags;
  } zone_t;

  // candidate broadcast to every cell
  typedef struct packed {
    logic              vld;
    logic [DIST_W-1:0] sqd;
    logic [IDX_W-1:0]  idx;
  } cand_t;

  // contents of one cell, handed to the next cell
  typedef struct packed {
    logic              used;
    logic [DIST_W-1:0] sqd;
    logic [IDX_W-1:0]  idx;
  } slot_t;

endpackage

[hw/rtl/nkps_if.sv]
// ----------------------------------------------------------------------------
// nkps_if
// Valid/ready channel interfaces for input items and result items.
// ----------------------------------------------------------------------------
interface nkps_in_if import nkps_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [IDX_W-1:0]          zone_index;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;
  logic signed [COORD_W-1:0] dest_x;
  logic signed [COORD_W-1:0] dest_y;
  logic signed [COORD_W-1:0] dest_z;
  logic signed [COORD_W-1:0] zone_distance;
  logic [FLAGS_W-1:0]        zone_flags;

  modport source (
    output valid, func, zone_index, coord_x, coord_y, coord_z,
           dest_x, dest_y, dest_z, zone_distance, zone_flags,
    input  ready
  );
  modport sink (
    input  valid, func, zone_index, coord_x, coord_y, coord_z,
           dest_x, dest_y, dest_z, zone_distance, zone_flags,
    output ready
  );
endinterface

interface nkps_out_if import nkps_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] out_anchor_x;
  logic signed [COORD_W-1:0] out_anchor_y;
  logic signed [COORD_W-1:0] out_anchor_z;
  logic signed [COORD_W-1:0] out_landing_x;
  logic signed [COORD_W-1:0] out_landing_y;
  logic signed [COORD_W-1:0] out_landing_z;
  logic signed [COORD_W-1:0] out_distance;
  logic [FLAGS_W-1:0]        out_flags;
  logic [RANK_W-1:0]         rank;
  logic                      valid_res;
  logic                      last;

  modport source (
    output valid, out_anchor_x, out_anchor_y, out_anchor_z, out_landing_x,
           out_landing_y, out_landing_z, out_distance, out_flags, rank,
           valid_res, last,
    input  ready
  );
  modport sink (
    input  valid, out_anchor_x, out_anchor_y, out_anchor_z, out_landing_x,
           out_landing_y, out_landing_z, out_distance, out_flags, rank,
           valid_res, last,
    output ready
  );
endinterface

[hw/rtl/nkps_ram.sv]
// ----------------------------------------------------------------------------
// nkps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nkps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/nkps_sqdist.sv]
// ----------------------------------------------------------------------------
// nkps_sqdist
// Two-stage squared distance unit: per-axis squares, then their sum.
// ----------------------------------------------------------------------------
module nkps_sqdist import nkps_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      vld_in,
  input  logic [IDX_W-1:0]          idx_in,
  input  zone_t                     zone,
  input  logic signed [COORD_W-1:0] qx,
  input  logic signed [COORD_W-1:0] qy,
  input  logic signed [COORD_W-1:0] qz,
  output cand_t                     cand,
  output logic                      busy
);

  // square of the difference of two coordinates
  function automatic logic [SQ_W-1:0] sq_diff(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    logic signed [DIFF_W-1:0] d;
    logic [DIFF_W-1:0]        m;
    d = DIFF_W'(a) - DIFF_W'(b);
    m = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    return SQ_W'(m) * SQ_W'(m);
  endfunction

  logic              s1_vld_r;
  logic [IDX_W-1:0]  s1_idx_r;
  logic [SQ_W-1:0]   sq_x_r, sq_y_r, sq_z_r;
  cand_t             cand_r;

  // stage one: squares per axis
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= vld_in;
    end
    s1_idx_r <= idx_in;
    sq_x_r   <= sq_diff(zone.base_x, qx);
    sq_y_r   <= sq_diff(zone.base_y, qy);
    sq_z_r   <= sq_diff(zone.base_z, qz);
  end

  // stage two: sum of the three squares
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r.vld <= 1'b0;
    end else begin
      cand_r.vld <= s1_vld_r;
    end
    cand_r.idx <= s1_idx_r;
    cand_r.sqd <= DIST_W'(sq_x_r) + DIST_W'(sq_y_r) + DIST_W'(sq_z_r);
  end

  assign cand = cand_r;
  assign busy = s1_vld_r | cand_r.vld;

endmodule

[hw/rtl/nkps_cell.sv]
// ----------------------------------------------------------------------------
// nkps_cell
// One slot of the sorted nearest list: insert here, shift from the
// neighbor, or hold.
// ----------------------------------------------------------------------------
module nkps_cell import nkps_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  clr,
  input  cand_t cand,
  input  logic  prev_ins,
  input  slot_t prev_slot,
  output logic  ins,
  output slot_t slot
);

  slot_t slot_r, slot_nxt;

  // candidate belongs at or before this slot
  assign ins = !slot_r.used || (cand.sqd < slot_r.sqd);

  // neighbor shift wins over local insert
  always_comb begin
    slot_nxt = slot_r;
    if (clr) begin
      slot_nxt = '0;
    end else if (cand.vld) begin
      if (prev_ins) begin
        slot_nxt = prev_slot;
      end else if (ins) begin
        slot_nxt.used = 1'b1;
        slot_nxt.sqd  = cand.sqd;
        slot_nxt.idx  = cand.idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  assign slot = slot_r;

endmodule

[hw/rtl/nearest_k_point_selector.sv]
// ----------------------------------------------------------------------------
// nearest_k_point_selector
// Zone table with a nearest-k query built on a chain of sorting cells.
// ----------------------------------------------------------------------------
// A write transaction stores one zone in the table. A query transaction
// reads the first zone_count entries (capped at 256) from the table RAM,
// one per cycle through its single read port, forms the squared distance
// in a two-stage unit and feeds it to a chain of 8 cells that keep the
// nearest zones sorted, earlier index first on a tie. After the scan the
// kept zones are read back one at a time and sent nearest first, each
// waiting while the result channel stalls; with no zones a single empty
// result is sent.
// The table comes out of reset unwritten: query only entries written before.
module nearest_k_point_selector import nkps_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  nkps_in_if.sink          in_ch,
  nkps_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SCAN    = 3'd1;
  localparam logic [2:0] ST_DRAIN   = 3'd2;
  localparam logic [2:0] ST_EMIT_RD = 3'd3;
  localparam logic [2:0] ST_EMIT_WR = 3'd4;
  localparam logic [2:0] ST_EMPTY   = 3'd5;

  logic [2:0]                state_r, state_nxt;
  logic [CFG_W-1:0]          zone_count_r;
  logic [CFG_W-1:0]          count_eff;
  logic [IDX_W-1:0]          last_idx_r, last_idx_nxt;
  logic [IDX_W-1:0]          scan_idx_r, scan_idx_nxt;
  logic [K_W-1:0]            k_r, k_nxt;
  logic signed [COORD_W-1:0] qx_r, qy_r, qz_r;
  logic                      p1_vld_r;
  logic [IDX_W-1:0]          p1_idx_r;

  logic                      in_fire, is_query, out_free, clr;
  logic                      ram_we, ram_re;
  logic [IDX_W-1:0]          ram_raddr;
  zone_t                     wr_zone, rd_zone;
  cand_t                     cand;
  logic                      sq_busy;

  slot_t                     cell_slot [NEAREST_COUNT];
  logic [NEAREST_COUNT-1:0]  cell_ins;
  logic [NEAREST_COUNT-1:0]  used_vec;
  logic                      last_k;

  logic                      out_valid_r, out_valid_nxt;
  logic                      load_zone, load_empty;
  zone_t                     out_zone_r;
  logic [RANK_W-1:0]         out_rank_r;
  logic                      out_vres_r, out_last_r;

  // handshake
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign is_query    = (in_ch.func == FUNC_QUERY);
  assign out_free    = !out_valid_r || out_ch.ready;
  assign clr         = in_fire && is_query;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_count_r <= '0;
    end else if (cfg_we) begin
      zone_count_r <= cfg_wdata;
    end
  end

  assign count_eff = (zone_count_r > CFG_W'(MAX_ZONES)) ? CFG_W'(MAX_ZONES)
                                                        : zone_count_r;

  // zone table
  always_comb begin
    wr_zone.base_x   = in_ch.coord_x;
    wr_zone.base_y   = in_ch.coord_y;
    wr_zone.base_z   = in_ch.coord_z;
    wr_zone.dest_x   = in_ch.dest_x;
    wr_zone.dest_y   = in_ch.dest_y;
    wr_zone.dest_z   = in_ch.dest_z;
    wr_zone.distance = in_ch.zone_distance;
    wr_zone.flags    = in_ch.zone_flags;
  end

  assign ram_we    = in_fire && (in_ch.func == FUNC_WRITE);
  assign ram_re    = (state_r == ST_SCAN) || (state_r == ST_EMIT_RD);
  assign ram_raddr = (state_r == ST_SCAN) ? scan_idx_r : cell_slot[k_r].idx;

  nkps_ram #(
    .WIDTH ($bits(zone_t)),
    .DEPTH (MAX_ZONES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_ch.zone_index),
    .wdata (wr_zone),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_zone)
  );

  // read-valid tracking for the scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= (state_r == ST_SCAN);
    end
    p1_idx_r <= scan_idx_r;
  end

  // squared distance unit
  nkps_sqdist u_sqdist (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_in (p1_vld_r),
    .idx_in (p1_idx_r),
    .zone   (rd_zone),
    .qx     (qx_r),
    .qy     (qy_r),
    .qz     (qz_r),
    .cand   (cand),
    .busy   (sq_busy)
  );

  // chain of sorting cells
  for (genvar g = 0; g < NEAREST_COUNT; g++) begin : g_cell
    logic  prev_ins;
    slot_t prev_slot;
    if (g == 0) begin : g_head
      assign prev_ins  = 1'b0;
      assign prev_slot = '0;
    end else begin : g_body
      assign prev_ins  = cell_ins[g-1];
      assign prev_slot = cell_slot[g-1];
    end
    nkps_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .clr       (clr),
      .cand      (cand),
      .prev_ins  (prev_ins),
      .prev_slot (prev_slot),
      .ins       (cell_ins[g]),
      .slot      (cell_slot[g])
    );
    assign used_vec[g] = cell_slot[g].used;
  end

  // final kept zone of the list
  assign last_k = (k_r == K_W'(NEAREST_COUNT - 1)) ? 1'b1 : !used_vec[k_r + 1'b1];

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    scan_idx_nxt = scan_idx_r;
    last_idx_nxt = last_idx_r;
    k_nxt        = k_r;
    load_zone    = 1'b0;
    load_empty   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (clr) begin
          scan_idx_nxt = '0;
          k_nxt        = '0;
          last_idx_nxt = IDX_W'(count_eff - 1'b1);
          state_nxt    = (count_eff == '0) ? ST_EMPTY : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_idx_r == last_idx_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!p1_vld_r && !sq_busy) begin
          state_nxt = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        if (out_free) begin
          load_zone = 1'b1;
          if (last_k) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          load_empty = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    scan_idx_r <= scan_idx_nxt;
    last_idx_r <= last_idx_nxt;
    k_r        <= k_nxt;
  end

  // query position capture
  always_ff @(posedge clk) begin
    if (clr) begin
      qx_r <= in_ch.coord_x;
      qy_r <= in_ch.coord_y;
      qz_r <= in_ch.coord_z;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_zone || load_empty) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (load_zone) begin
      out_zone_r <= rd_zone;
      out_rank_r <= RANK_W'(k_r);
      out_vres_r <= 1'b1;
      out_last_r <= last_k;
    end else if (load_empty) begin
      out_zone_r <= '0;
      out_rank_r <= '0;
      out_vres_r <= 1'b0;
      out_last_r <= 1'b1;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_anchor_x  = out_zone_r.base_x;
  assign out_ch.out_anchor_y  = out_zone_r.base_y;
  assign out_ch.out_anchor_z  = out_zone_r.base_z;
  assign out_ch.out_landing_x = out_zone_r.dest_x;
  assign out_ch.out_landing_y = out_zone_r.dest_y;
  assign out_ch.out_landing_z = out_zone_r.dest_z;
  assign out_ch.out_distance  = out_zone_r.distance;
  assign out_ch.out_flags     = out_zone_r.flags;
  assign out_ch.rank          = out_rank_r;
  assign out_ch.valid_res     = out_vres_r;
  assign out_ch.last          = out_last_r;

  // kept zones always form an unbroken run from the nearest cell
  a_used_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (used_vec & NEAREST_COUNT'(used_vec + 1'b1)) == '0)
    else $error("nearest list has a gap");

  // an empty result always closes its query
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.valid_res |-> out_ch.last)
    else $error("empty result without last");

  // the table is never written while a query is in progress
  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !ram_we)
    else $error("table write during query");

  // the scan unit is empty when results start to be read back
  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT_RD |-> !p1_vld_r && !sq_busy)
    else $error("read back before scan drained");

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the nearest-k point selector. A tracker class keeps
// its own copy of the zone table and the zone count, predicts the nearest
// zones of every accepted query and checks each result transaction in order.
// Directed cases cover the field extremes, ties and the empty table; random
// phases then sweep several zone counts under varying back-pressure.
// ----------------------------------------------------------------------------
module testbench;
  import nkps_pkg::*;

  typedef logic signed [COORD_W-1:0] coord_t;

  // one input transaction: zone payload doubles as query position
  typedef struct packed {
    logic             func;
    logic [IDX_W-1:0] zone_index;
    zone_t            zone;
  } in_item_t;

  // one result transaction, same field order as the result channel
  typedef struct packed {
    zone_t             zone;
    logic [RANK_W-1:0] rank;
    logic              valid_res;
    logic              last;
  } result_t;

  localparam coord_t C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam int     WRITE_SETTLE = 16;
  localparam int     DRAIN_CYCLES = 300;

  // zone table copy, nearest-k prediction and result checking
  class zone_tracker;
    zone_t       zone_table [MAX_ZONES];
    bit          written [MAX_ZONES];
    int unsigned zone_count;
    result_t     pending_results [$];
    int          errors;

    function new();
      zone_count = 0;
      errors     = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    // exact squared distance between a stored anchor and a query position
    function longint unsigned sq_dist(zone_t entry, zone_t pos);
      longint dx, dy, dz;
      dx = longint'(entry.base_x) - longint'(pos.base_x);
      dy = longint'(entry.base_y) - longint'(pos.base_y);
      dz = longint'(entry.base_z) - longint'(pos.base_z);
      return longint'(dx * dx + dy * dy + dz * dz);
    endfunction

    // update the table or predict the results of one accepted transaction
    function void apply_item(in_item_t it);
      int unsigned       eff, n_kept, pos, k, i;
      longint unsigned   sqd;
      longint unsigned   kept_dist [NEAREST_COUNT];
      int unsigned       kept_idx [NEAREST_COUNT];
      result_t           res;
      if (it.func == FUNC_WRITE) begin
        zone_table[it.zone_index] = it.zone;
        written[it.zone_index]    = 1'b1;
        return;
      end
      eff = (zone_count > MAX_ZONES) ? MAX_ZONES : zone_count;
      // empty table gives one result with no zone
      if (eff == 0) begin
        res      = '0;
        res.last = 1'b1;
        pending_results.push_back(res);
        return;
      end
      // sorted insertion, equal distance stays behind the earlier index
      n_kept = 0;
      for (i = 0; i < eff; i++) begin
        sqd = sq_dist(zone_table[i], it.zone);
        pos = 0;
        while (pos < n_kept && kept_dist[pos] <= sqd) pos++;
        if (pos < NEAREST_COUNT) begin
          for (k = (n_kept < NEAREST_COUNT) ? n_kept : NEAREST_COUNT - 1; k > pos; k--) begin
            kept_dist[k] = kept_dist[k-1];
            kept_idx[k]  = kept_idx[k-1];
          end
          kept_dist[pos] = sqd;
          kept_idx[pos]  = i;
          if (n_kept < NEAREST_COUNT) n_kept++;
        end
      end
      for (k = 0; k < n_kept; k++) begin
        res.zone      = zone_table[kept_idx[k]];
        res.rank      = RANK_W'(k);
        res.valid_res = 1'b1;
        res.last      = (k == n_kept - 1);
        pending_results.push_back(res);
      end
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // compare one result transaction with the oldest prediction
    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual rank %0d last %0d",
                 $time, got.rank, got.last);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("out_anchor_x", want.zone.base_x, got.zone.base_x);
      compare_field("out_anchor_y", want.zone.base_y, got.zone.base_y);
      compare_field("out_anchor_z", want.zone.base_z, got.zone.base_z);
      compare_field("out_landing_x", want.zone.dest_x, got.zone.dest_x);
      compare_field("out_landing_y", want.zone.dest_y, got.zone.dest_y);
      compare_field("out_landing_z", want.zone.dest_z, got.zone.dest_z);
      compare_field("out_distance", want.zone.distance, got.zone.distance);
      compare_field("out_flags", want.zone.flags, got.zone.flags);
      compare_field("rank", want.rank, got.rank);
      compare_field("valid_res", want.valid_res, got.valid_res);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  int               send_idle_pct = 11;
  int               recv_idle_pct = 49;
  int unsigned      phase_count [8] = '{1, 8, 9, 37, 256, 511, 5, 16};
  int unsigned      phase_items [8] = '{18, 18, 18, 18, 14, 14, 18, 18};
  zone_tracker      tracker = new();
  result_t          out_seen;

  nkps_in_if  in_if ();
  nkps_out_if out_if ();

  nearest_k_point_selector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #8000000;
    $display("testbench NOT OK");
    $finish;
  end

  assign out_seen = {out_if.out_anchor_x, out_if.out_anchor_y, out_if.out_anchor_z,
                     out_if.out_landing_x, out_if.out_landing_y, out_if.out_landing_z,
                     out_if.out_distance, out_if.out_flags, out_if.rank,
                     out_if.valid_res, out_if.last};

  // result receiver with random stalls
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) tracker.check_result(out_seen);
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // coordinate mix: full range, near origin, or edge values
  function automatic coord_t rand_coord();
    case ($urandom_range(2))
      0:       return coord_t'($urandom);
      1:       return coord_t'(int'($urandom_range(127)) - 64);
      default: begin
        case ($urandom_range(3))
          0:       return C_MIN;
          1:       return C_MAX;
          2:       return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  function automatic zone_t random_zone();
    zone_t z;
    z.base_x   = rand_coord();
    z.base_y   = rand_coord();
    z.base_z   = rand_coord();
    z.dest_x   = coord_t'($urandom);
    z.dest_y   = coord_t'($urandom);
    z.dest_z   = coord_t'($urandom);
    z.distance = coord_t'($urandom);
    z.flags    = FLAGS_W'($urandom);
    return z;
  endfunction

  function automatic in_item_t write_item(int unsigned idx, zone_t z);
    in_item_t it;
    it.func       = FUNC_WRITE;
    it.zone_index = IDX_W'(idx);
    it.zone       = z;
    return it;
  endfunction

  // query position rides in the anchor fields, the rest is don't-care noise
  function automatic in_item_t query_item(coord_t x, coord_t y, coord_t z);
    in_item_t it;
    it.func        = FUNC_QUERY;
    it.zone_index  = IDX_W'($urandom);
    it.zone        = random_zone();
    it.zone.base_x = x;
    it.zone.base_y = y;
    it.zone.base_z = z;
    return it;
  endfunction

  // drive one input transaction and wait for its acceptance
  task automatic send_item(input in_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.func          <= it.func;
    in_if.zone_index    <= it.zone_index;
    in_if.coord_x       <= it.zone.base_x;
    in_if.coord_y       <= it.zone.base_y;
    in_if.coord_z       <= it.zone.base_z;
    in_if.dest_x        <= it.zone.dest_x;
    in_if.dest_y        <= it.zone.dest_y;
    in_if.dest_z        <= it.zone.dest_z;
    in_if.zone_distance <= it.zone.distance;
    in_if.zone_flags    <= it.zone.flags;
    do @(posedge clk); while (!in_if.ready);
    tracker.apply_item(it);
  endtask

  // write the zone count once the block has gone quiet
  task automatic set_zone_count(input int unsigned count);
    in_if.valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (WRITE_SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CFG_W'(count);
    @(posedge clk);
    cfg_we             <= 1'b0;
    tracker.zone_count = count;
  endtask

  // stimulus
  initial begin
    zone_t       z;
    int unsigned eff, idx, j, i, p;
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    in_if.valid         <= 1'b0;
    in_if.func          <= FUNC_WRITE;
    in_if.zone_index    <= '0;
    in_if.coord_x       <= '0;
    in_if.coord_y       <= '0;
    in_if.coord_z       <= '0;
    in_if.dest_x        <= '0;
    in_if.dest_y        <= '0;
    in_if.dest_z        <= '0;
    in_if.zone_distance <= '0;
    in_if.zone_flags    <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty table right after reset
    send_item(query_item('0, '0, '0));

    // extreme entries, a tied pair and a few random ones
    z = random_zone();
    z.base_x   = C_MAX; z.base_y = C_MAX; z.base_z = C_MAX;
    z.dest_x   = C_MIN; z.dest_y = C_MIN; z.dest_z = C_MIN;
    z.distance = C_MAX; z.flags  = '1;
    send_item(write_item(0, z));
    z = random_zone();
    z.base_x   = C_MIN; z.base_y = C_MIN; z.base_z = C_MIN;
    z.dest_x   = C_MAX; z.dest_y = C_MAX; z.dest_z = C_MAX;
    z.distance = C_MIN; z.flags  = '0;
    send_item(write_item(1, z));
    z = random_zone();
    z.base_x = '0; z.base_y = '0; z.base_z = '0; z.flags = 16'h5a5a;
    send_item(write_item(2, z));
    z.flags = 16'ha5a5;
    send_item(write_item(3, z));
    z = random_zone();
    z.base_x = coord_t'(1); z.base_y = coord_t'(-1); z.base_z = '0;
    send_item(write_item(4, z));
    for (i = 5; i < 9; i++) send_item(write_item(i, random_zone()));
    send_item(write_item(MAX_ZONES - 1, random_zone()));

    // more zones than kept, then fewer, then none
    set_zone_count(9);
    send_item(query_item('0, '0, '0));
    send_item(query_item(C_MAX, C_MAX, C_MAX));
    send_item(query_item(C_MIN, C_MIN, C_MIN));
    send_item(query_item(C_MIN, C_MAX, '0));
    set_zone_count(2);
    send_item(query_item('0, '0, '0));
    set_zone_count(1);
    send_item(query_item(C_MAX, C_MIN, C_MAX));
    set_zone_count(0);
    send_item(query_item('0, '0, '0));

    // random phases over several zone counts
    for (p = 0; p < 8; p++) begin
      if (p == 3) begin
        send_idle_pct = 49;
        recv_idle_pct = 11;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_zone_count(phase_count[p]);
      eff = (phase_count[p] > MAX_ZONES) ? MAX_ZONES : phase_count[p];
      // every entry a query can reach must hold a zone
      for (i = 0; i < eff; i++)
        if (!tracker.written[i]) send_item(write_item(i, random_zone()));
      for (i = 0; i < phase_items[p]; i++) begin
        if ($urandom_range(99) < 40) begin
          if ($urandom_range(99) < 30) begin
            // query exactly on a stored anchor
            z = tracker.zone_table[$urandom_range(eff - 1)];
            send_item(query_item(z.base_x, z.base_y, z.base_z));
          end else begin
            send_item(query_item(rand_coord(), rand_coord(), rand_coord()));
          end
        end else begin
          idx = ($urandom_range(99) < 70) ? $urandom_range(eff - 1)
                                          : $urandom_range(MAX_ZONES - 1);
          z = random_zone();
          if ($urandom_range(99) < 25) begin
            // copy another anchor to provoke ties
            j = $urandom_range(eff - 1);
            z.base_x = tracker.zone_table[j].base_x;
            z.base_y = tracker.zone_table[j].base_y;
            z.base_z = tracker.zone_table[j].base_z;
          end
          send_item(write_item(idx, z));
        end
      end
    end

    // drain and let any stray result show up
    in_if.valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
